/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define FPRX_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fprx assertion failed");

// Expression must never be true at a rising edge outside reset.
`define FPRX_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("fprx forbidden condition seen");

`endif

/* hw/rtl/fprx_pkg.sv */
// Package: constants, register indexes and state type of the frame receiver.
package fprx_pkg;

    localparam int BYTE_W              = 8;
    localparam int MAX_FRAME_BYTES_DEF = 32;
    localparam int CFG_IDX_W           = 1;
    localparam int USER_W              = 2;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'b1;

    typedef enum logic [1:0] {
        ST_RX,
        ST_RD,
        ST_OUT
    } fprx_state_t;

endpackage

/* hw/rtl/framed_packet_receiver_xor_check_core.sv */
// Top level: start/end byte deframer with XOR frame check and payload drain.
//
//  channel  | direction | handshake                   | contents
//  ---------+-----------+-----------------------------+-------------------------------
//  cfg      | in        | cfg_we                      | cfg_index, cfg_data (markers)
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | rx_byte
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | payload_byte, tlast, tuser flags
//
//  Rate: one received byte per cycle while no frame is draining.
//  A closed frame drains from the frame store one result at a time, each
//  through a RAM read state (ST_RD) and then an output state (ST_OUT);
//  an empty frame goes straight to ST_OUT with one empty result.
//  s_axis_tready is low during the drain; m_axis stalls hold the result.
//  Reset clears control state only; the frame store needs no clearing pass.
module framed_packet_receiver_xor_check_core #(
    parameter int MAX_FRAME_BYTES = fprx_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [fprx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fprx_pkg::BYTE_W-1:0]    cfg_data,
    // received bytes
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [fprx_pkg::BYTE_W-1:0]    s_axis_tdata,  // [7:0] rx_byte
    // frame payload results
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [fprx_pkg::BYTE_W-1:0]    m_axis_tdata,  // [7:0] payload_byte
    output logic                           m_axis_tlast,  // is_last
    output logic [fprx_pkg::USER_W-1:0]    m_axis_tuser   // [0] frame_status, [1] payload_empty
);

    import fprx_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

    // Configuration registers
    logic [BYTE_W-1:0] start_reg;
    logic [BYTE_W-1:0] end_reg;

    // Frame control state
    fprx_state_t       state_reg, state_next;
    logic              in_frame_reg, in_frame_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [BYTE_W-1:0] check_reg, check_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [AW-1:0]     last_idx_reg, last_idx_next;
    logic              fail_reg, fail_next;
    logic              empty_reg, empty_next;

    // Frame store port signals
    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    logic              in_acc;
    logic              out_acc;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] check_x;
    logic [CW-1:0]     cnt_inc;
    logic              close;
    logic [CW-1:0]     close_cnt;
    logic [BYTE_W-1:0] close_chk;
    logic              out_last;

    fprx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Configuration writes: take effect on the next received byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_MARKER_RST;
            end_reg   <= END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_MARKER: start_reg <= cfg_data;
                CFG_END_MARKER:   end_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign rx_byte  = s_axis_tdata;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign check_x  = check_reg ^ rx_byte;
    assign cnt_inc  = count_reg + CW'(1);
    assign out_last = empty_reg || (rd_idx_reg == last_idx_reg);

    // Output side: the RAM read register holds the byte during a stall.
    assign s_axis_tready = (state_reg == ST_RX);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = empty_reg ? '0 : ram_rdata;
    assign m_axis_tlast  = out_last;
    assign m_axis_tuser  = {empty_reg, fail_reg & out_last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RX;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            check_reg    <= '0;
            rd_idx_reg   <= '0;
            last_idx_reg <= '0;
            fail_reg     <= 1'b0;
            empty_reg    <= 1'b0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            check_reg    <= check_next;
            rd_idx_reg   <= rd_idx_next;
            last_idx_reg <= last_idx_next;
            fail_reg     <= fail_next;
            empty_reg    <= empty_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        check_next    = check_reg;
        rd_idx_next   = rd_idx_reg;
        last_idx_next = last_idx_reg;
        fail_next     = fail_reg;
        empty_next    = empty_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        close         = 1'b0;
        close_cnt     = count_reg;
        close_chk     = check_reg;

        unique case (state_reg)
            ST_RX:
            begin
                if (in_acc)
                begin
                    if (!in_frame_reg)
                    begin
                        // Wait for the start byte; seed the check with it.
                        if (rx_byte == start_reg)
                        begin
                            in_frame_next = 1'b1;
                            count_next    = '0;
                            check_next    = start_reg;
                        end
                    end
                    else if (rx_byte == end_reg)
                    begin
                        close     = 1'b1;
                        close_cnt = count_reg;
                        close_chk = check_x;
                    end
                    else if (rx_byte == start_reg)
                    begin
                        // Restart: drop the partial frame.
                        count_next = '0;
                        check_next = start_reg;
                    end
                    else
                    begin
                        // Store the byte; close when the store fills.
                        ram_we     = 1'b1;
                        count_next = cnt_inc;
                        check_next = check_x;
                        if (cnt_inc == CW'(MAX_FRAME_BYTES))
                        begin
                            close     = 1'b1;
                            close_cnt = cnt_inc;
                            close_chk = check_x;
                        end
                    end
                end

                if (close)
                begin
                    in_frame_next = 1'b0;
                    count_next    = '0;
                    check_next    = '0;
                    fail_next     = (close_chk != '0);
                    rd_idx_next   = '0;
                    if (close_cnt <= CW'(1))
                    begin
                        // At most the check byte stored: one empty result.
                        empty_next = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        // Last stored byte is the check byte: skip it.
                        empty_next    = 1'b0;
                        last_idx_next = close_cnt[AW-1:0] - AW'(2);
                        state_next    = ST_RD;
                    end
                end
            end

            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (out_acc)
                begin
                    if (out_last)
                    begin
                        empty_next = 1'b0;
                        state_next = ST_RX;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                        state_next  = ST_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_RX;
            end
        endcase
    end

endmodule

/* hw/rtl/fprx_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fprx_ram #(
    parameter int WIDTH = fprx_pkg::BYTE_W,
    parameter int DEPTH = fprx_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/fprx_checker.sv */
// Checker on the ports of the frame receiver, bound to its top level.
`include "assert_macros.svh"

module fprx_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [fprx_pkg::BYTE_W-1:0]    m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic [fprx_pkg::USER_W-1:0]    m_axis_tuser
);

    // Hold a stalled result unchanged.
    `FPRX_ASSERT(a_out_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser)))

    // Input is never taken while a result is on offer.
    `FPRX_NEVER(a_no_overlap, clk, rst_n, s_axis_tready && m_axis_tvalid)

    // Empty-frame result is the only result of its frame and carries zero data.
    `FPRX_ASSERT(a_empty_last, clk, rst_n, (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && (m_axis_tdata == '0)))

    // Check status shows on the last result only.
    `FPRX_ASSERT(a_status_last, clk, rst_n, (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)

    // Reopen input right after the last result of a frame is taken.
    `FPRX_ASSERT(a_resume, clk, rst_n, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (s_axis_tready && !m_axis_tvalid))

endmodule

bind framed_packet_receiver_xor_check_core fprx_checker u_fprx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* dv/tb_framed_packet_receiver_xor_check_core.sv */
// Testbench for the framed packet receiver: directed frames, random framing, XOR status checks.
module tb_framed_packet_receiver_xor_check_core;

    import fprx_pkg::*;

    localparam int FRAME_DEPTH   = MAX_FRAME_BYTES_DEF;
    localparam int ITEM_TARGET   = 470;   // counted bytes: frame openers and in-frame bytes
    localparam int SETTLE_CYCLES = 6;     // lets a byte that causes no result finish
    localparam int TAIL_CYCLES   = 64;
    localparam int MAX_REPORTS   = 30;
    localparam int RUN_LIMIT     = 5000000;

    // tuser bit positions and status codes of the result stream
    localparam int USER_STATUS_BIT = 0;
    localparam int USER_EMPTY_BIT  = 1;
    localparam logic STATUS_PASS   = 1'b0;
    localparam logic STATUS_FAIL   = 1'b1;

    typedef logic [BYTE_W-1:0] rx_byte_t;

    typedef struct packed {
        rx_byte_t payload_byte;
        logic     is_last;
        logic     frame_status;
        logic     payload_empty;
    } frame_result_t;

    localparam frame_result_t EMPTY_PASS = {8'h00, 1'b1, STATUS_PASS, 1'b1};
    localparam frame_result_t EMPTY_FAIL = {8'h00, 1'b1, STATUS_FAIL, 1'b1};

    typedef enum logic { ROW_RX, ROW_CFG } stim_kind_t;

    typedef struct {
        stim_kind_t               kind;
        rx_byte_t                 value;
        bit                       typed;
        frame_result_t            want;
        logic [CFG_IDX_W-1:0]     reg_index;
    } stim_row_t;

    // DUT ports
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [BYTE_W-1:0]     cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;   // [7:0] rx_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [BYTE_W-1:0]     m_axis_tdata;   // [7:0] payload_byte
    logic                  m_axis_tlast;
    logic [USER_W-1:0]     m_axis_tuser;   // [0] frame_status, [1] payload_empty

    // Deframer state as predicted from the accepted bytes
    rx_byte_t      pred_start_marker;
    rx_byte_t      pred_end_marker;
    bit            rx_in_frame;
    int            rx_count;
    rx_byte_t      rx_check;
    rx_byte_t      rx_store [FRAME_DEPTH];

    frame_result_t fresh_payload [$];   // results caused by the byte just accepted
    frame_result_t pending_payload [$]; // results still owed by the block
    stim_row_t     directed_rows [$];

    int  error_count    = 0;
    int  rx_counted     = 0;
    int  results_seen   = 0;
    int  frames_seen    = 0;
    int  marker_phases  = 0;
    int  sink_stall     = 0;
    bit  src_steady     = 1'b0;
    bit  sink_steady    = 1'b0;

    framed_packet_receiver_xor_check_core #(
        .MAX_FRAME_BYTES(FRAME_DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Hard stop in case a handshake never completes
    initial
    begin
        #(RUN_LIMIT);
        $display("Timeout: run stopped with %0d results still owed", pending_payload.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Idle length: mostly short, now and then a long hold
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random body byte that neither opens nor closes a frame
    function automatic rx_byte_t plain_byte();
        rx_byte_t b;
        do
            b = rx_byte_t'($urandom_range(0, 255));
        while (b == pred_start_marker || b == pred_end_marker);
        return b;
    endfunction

    // Close the frame: emit the body minus the trailing check byte
    task automatic close_frame();
        logic status;
        status = (rx_check != 8'h00) ? STATUS_FAIL : STATUS_PASS;
        if (rx_count <= 1)
            fresh_payload.push_back({8'h00, 1'b1, status, 1'b1});
        else
            for (int i = 0; i < rx_count - 1; i++)
                fresh_payload.push_back({rx_store[i], (i == rx_count - 2),
                                         (i == rx_count - 2) ? status : STATUS_PASS, 1'b0});
        rx_in_frame = 1'b0;
        rx_count    = 0;
        rx_check    = 8'h00;
    endtask

    // Advance the predicted deframer by one accepted byte
    task automatic predict_rx(input rx_byte_t b, output bit ignored);
        ignored = 1'b0;
        if (!rx_in_frame)
        begin
            if (b == pred_start_marker)
            begin
                rx_in_frame = 1'b1;
                rx_count    = 0;
                rx_check    = pred_start_marker;
            end
            else
                ignored = 1'b1;
        end
        else if (b == pred_end_marker)
        begin
            // end wins over start when both markers are equal
            rx_check = rx_check ^ b;
            close_frame();
        end
        else if (b == pred_start_marker)
        begin
            // restart: drop the partial frame and reseed the check
            rx_count = 0;
            rx_check = pred_start_marker;
        end
        else
        begin
            rx_check = rx_check ^ b;
            if (rx_count < FRAME_DEPTH)
            begin
                rx_store[rx_count] = b;
                rx_count++;
            end
            if (rx_count >= FRAME_DEPTH)
                close_frame();
        end
    endtask

    // Offer one item, hold it until accepted, then book its results
    task automatic send_byte(input rx_byte_t b, input bit typed = 1'b0,
                             input frame_result_t want = '0);
        int gap;
        bit ignored;
        gap = (!src_steady && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_rx(b, ignored);
        if (!ignored)
            rx_counted++;
        if (typed)
        begin
            fresh_payload.delete();
            pending_payload.push_back(want);
        end
        else
            while (fresh_payload.size() != 0)
                pending_payload.push_back(fresh_payload.pop_front());
    endtask

    // Wait for every owed result, then let a result-free byte finish
    task automatic wait_idle();
        while (pending_payload.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input rx_byte_t val);
        s_axis_tvalid <= 1'b0;
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_START_MARKER)
            pred_start_marker = val;
        else
            pred_end_marker = val;
    endtask

    task automatic add_row(input stim_kind_t kind, input rx_byte_t val,
                           input bit typed = 1'b0, input frame_result_t want = '0,
                           input logic [CFG_IDX_W-1:0] idx = CFG_START_MARKER);
        stim_row_t row;
        row.kind      = kind;
        row.value     = val;
        row.typed     = typed;
        row.want      = want;
        row.reg_index = idx;
        directed_rows.push_back(row);
    endtask

    // Result sink: random stalls, with steady stretches per phase
    always @(posedge clk)
    begin
        if (sink_stall == 0 && !sink_steady && $urandom_range(0, 99) < 20)
            sink_stall = idle_len();
        if (sink_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_stall--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare every accepted result with the oldest owed one
    always @(posedge clk)
    begin : payload_monitor
        frame_result_t got;
        frame_result_t want;
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            got = {m_axis_tdata, m_axis_tlast, m_axis_tuser[USER_STATUS_BIT],
                   m_axis_tuser[USER_EMPTY_BIT]};
            if (pending_payload.size() == 0)
                report_mismatch($sformatf("unexpected result %h", got));
            else
            begin
                want = pending_payload.pop_front();
                results_seen++;
                if (want.is_last)
                    frames_seen++;
                if (got.payload_byte !== want.payload_byte)
                    report_mismatch($sformatf("payload_byte %h, want %h",
                                              got.payload_byte, want.payload_byte));
                if (got.is_last !== want.is_last)
                    report_mismatch($sformatf("is_last %b, want %b",
                                              got.is_last, want.is_last));
                if (got.frame_status !== want.frame_status)
                    report_mismatch($sformatf("frame_status %b, want %b",
                                              got.frame_status, want.frame_status));
                if (got.payload_empty !== want.payload_empty)
                    report_mismatch($sformatf("payload_empty %b, want %b",
                                              got.payload_empty, want.payload_empty));
            end
        end
    end

    initial
    begin
        rx_byte_t s_val;
        rx_byte_t e_val;
        rx_byte_t body_xor;
        rx_byte_t v;
        int       n_frames;
        int       len;
        int       choice;

        // Drive every input to a known value and hold reset
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_START_MARKER;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        pred_start_marker = START_MARKER_RST;
        pred_end_marker   = END_MARKER_RST;
        rx_in_frame       = 1'b0;
        rx_count          = 0;
        rx_check          = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset markers first (start 02, end 03)
        add_row(ROW_RX, 8'h03);                        // end byte outside a frame: drop
        add_row(ROW_RX, 8'h02);
        add_row(ROW_RX, 8'h03, 1'b1, EMPTY_FAIL);      // nothing stored, check 02^03 fails
        add_row(ROW_RX, 8'h02);
        add_row(ROW_RX, 8'h01);
        add_row(ROW_RX, 8'h03, 1'b1, EMPTY_PASS);      // only the check byte stored
        add_row(ROW_RX, 8'h02);
        add_row(ROW_RX, 8'h00);
        add_row(ROW_RX, 8'hFF);
        add_row(ROW_RX, 8'h02);                        // start inside a frame: restart
        add_row(ROW_RX, 8'h00);                        // zero bytes are plain data
        add_row(ROW_RX, 8'hFF);
        add_row(ROW_RX, 8'hFE);                        // check byte that makes the XOR zero
        add_row(ROW_RX, 8'h03);
        add_row(ROW_CFG, 8'hFF, 1'b0, '0, CFG_START_MARKER);
        add_row(ROW_RX, 8'hFF);
        add_row(ROW_RX, 8'h80);
        add_row(ROW_CFG, 8'h00, 1'b0, '0, CFG_END_MARKER);   // change end marker mid-frame
        add_row(ROW_RX, 8'h7F);
        add_row(ROW_RX, 8'h00);
        add_row(ROW_CFG, 8'hA5, 1'b0, '0, CFG_START_MARKER);
        add_row(ROW_CFG, 8'hA5, 1'b0, '0, CFG_END_MARKER);   // equal markers
        add_row(ROW_RX, 8'hA5);
        add_row(ROW_RX, 8'h11);
        add_row(ROW_RX, 8'hA5, 1'b1, EMPTY_FAIL);      // the shared marker closes the frame

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].reg_index, directed_rows[i].value);
            else
                send_byte(directed_rows[i].value, directed_rows[i].typed,
                          directed_rows[i].want);
        end

        // Random part: phases of marker settings, each with a batch of frames
        while (rx_counted < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    s_val = START_MARKER_RST;
                    e_val = END_MARKER_RST;
                end
                1:
                begin
                    s_val = 8'h00;
                    e_val = 8'hFF;
                end
                2:
                begin
                    s_val = 8'hFF;
                    e_val = 8'h00;
                end
                3:
                begin
                    s_val = rx_byte_t'($urandom_range(0, 255));
                    e_val = s_val;
                end
                default:
                begin
                    s_val = rx_byte_t'($urandom_range(0, 255));
                    e_val = rx_byte_t'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_START_MARKER, s_val);
            write_reg(CFG_END_MARKER, e_val);
            marker_phases++;
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);

            n_frames = $urandom_range(3, 8);
            for (int f = 0; f < n_frames; f++)
            begin
                choice = $urandom_range(0, 99);
                if (choice < 75)
                begin
                    // well-formed frame, sometimes after an abandoned partial one
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_byte(s_val);
                        repeat ($urandom_range(0, 3)) send_byte(plain_byte());
                    end
                    choice = $urandom_range(0, 99);
                    if (choice < 85)
                        len = $urandom_range(0, 6);
                    else if (choice < 95)
                        len = $urandom_range(7, 20);
                    else
                        len = $urandom_range(FRAME_DEPTH - 3, FRAME_DEPTH + 1);
                    send_byte(s_val);
                    body_xor = 8'h00;
                    for (int i = 0; i < len; i++)
                    begin
                        v = plain_byte();
                        body_xor ^= v;
                        send_byte(v);
                    end
                    if ($urandom_range(0, 9) < 7)
                        send_byte(s_val ^ e_val ^ body_xor);
                    else
                        send_byte(plain_byte());
                    send_byte(e_val);
                end
                else if (choice < 88)
                begin
                    // broken frame: any byte values, no guaranteed end
                    send_byte(s_val);
                    repeat ($urandom_range(1, 10))
                        send_byte(rx_byte_t'($urandom_range(0, 255)));
                end
                else
                begin
                    // line noise
                    repeat ($urandom_range(1, 6))
                        send_byte(rx_byte_t'($urandom_range(0, 255)));
                end
            end
        end

        // Drain: hold the input idle and let every owed result arrive
        s_axis_tvalid <= 1'b0;
        src_steady  = 1'b0;
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_payload.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_payload.size()));

        $display("Covered %0d counted bytes under %0d random marker settings plus directed rows",
                 rx_counted, marker_phases);
        $display("Checked %0d payload results closing %0d frames, %0d mismatches",
                 results_seen, frames_seen, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
